/* hdl/joint_energy_accumulator_core_defines.svh */
// Assertion macros shared by the joint energy accumulator.
`ifndef JOINT_ENERGY_ACCUMULATOR_CORE_DEFINES_SVH
`define JOINT_ENERGY_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while in reset.
`define JEA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while in reset.
`define JEA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/jea_pkg.sv */
package jea_pkg;

	// Number of joints and the width of a table index.
	localparam int JOINTS = 32;
	localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// Field widths of requests and results.
	localparam int JOINT_W = 5;
	localparam int POS_W   = 32;
	localparam int TRQ_W   = 32;
	localparam int GEAR_W  = 20;
	localparam int WIND_W  = 24;
	localparam int EN_W    = 48;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALPHA  = 2'd0,
		CFG_RATE   = 2'd1,
		CFG_PERIOD = 2'd2
	} cfg_idx_t;

	localparam logic [15:0] ALPHA_RST  = 16'd1966;
	localparam logic [15:0] RATE_RST   = 16'd200;
	localparam logic [23:0] PERIOD_RST = 24'd83886;

	typedef struct packed {
		logic [15:0] alpha;
		logic [15:0] rate;
		logic [23:0] period;
	} cfg_t;

	// Request kinds.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Shared multiplier operand widths.
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 33;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [EN_W-1:0] EN_FULL = '1;

	// Per-joint coefficients.
	typedef struct packed {
		logic [GEAR_W-1:0] gear;
		logic [WIND_W-1:0] wind;
	} coef_t;

	// Per-joint running state.
	typedef struct packed {
		logic [63:0]     last;
		logic [47:0]     fvel;
		logic [31:0]     ftrq;
		logic [EN_W-1:0] macc;
		logic [EN_W-1:0] wacc;
	} jstate_t;

	// Saturating 48-bit add; the top bit flags a clip.
	function automatic logic [EN_W:0] add_sat48(input logic [EN_W-1:0] a,
			input logic [EN_W-1:0] b);
		logic [EN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[EN_W]) begin
			s = {1'b1, EN_FULL};
		end
		return s;
	endfunction

endpackage

/* hdl/jea_in_if.sv */
interface jea_in_if import jea_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic [JOINT_W-1:0]       joint;
	logic                     first_sample;
	logic signed [POS_W-1:0]  position;
	logic signed [TRQ_W-1:0]  torque;
	logic [GEAR_W-1:0]        gear_ratio;
	logic [WIND_W-1:0]        winding_coef;

	modport source(output valid, req_type, joint, first_sample, position, torque,
		gear_ratio, winding_coef, input ready);
	modport sink(input valid, req_type, joint, first_sample, position, torque,
		gear_ratio, winding_coef, output ready);
endinterface

/* hdl/jea_out_if.sv */
interface jea_out_if import jea_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [JOINT_W-1:0] out_joint;
	logic [EN_W-1:0]    motor_energy;
	logic [EN_W-1:0]    walk_energy;
	logic [EN_W-1:0]    total_motor_energy;
	logic [EN_W-1:0]    total_walk_energy;
	logic               saturated;

	modport source(output valid, out_joint, motor_energy, walk_energy,
		total_motor_energy, total_walk_energy, saturated, input ready);
	modport sink(input valid, out_joint, motor_energy, walk_energy,
		total_motor_energy, total_walk_energy, saturated, output ready);
endinterface

/* hdl/jea_cfg_if.sv */
interface jea_cfg_if import jea_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* hdl/joint_energy_accumulator_core.sv */
// Sample request: result offered after the full step sequence; a first-of-run sample goes from scale to write-back.
// One sample at a time through one shared 34x33 multiplier (15 passes per sample);
// no new request is taken until write-back; coefficient loads complete while idle.
// Write-back stalls while the previous result waits on the output register.
// Per-joint state is read from and written back to one memory per sample request.
// Reset: configuration to defaults, totals zero, joint state reads as zero via
// per-joint valid bits; coefficient tables hold nothing until loaded.
`include "joint_energy_accumulator_core_defines.svh"

module joint_energy_accumulator_core import jea_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jea_in_if.sink    sample,
	jea_out_if.source result,
	jea_cfg_if.sink   cfg
);
	typedef enum logic [4:0] {
		S_IDLE, S_LD, S_SC, S_V0, S_V1, S_V2, S_F0, S_F1, S_F2, S_F3,
		S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
		S_AC, S_WB
	} state_t;

	state_t state_q;
	cfg_t   cfg_r;

	// Request latch.
	logic [JOINT_W-1:0] joint_q;
	logic [JIDX_W-1:0]  jidx_q;
	logic               first_q;
	logic [31:0]        pos_q;
	logic [31:0]        tau_q;

	// Working registers.
	logic [63:0]     last_q, scaled_q;
	logic [47:0]     fv_q, vel_q, av_q;
	logic [31:0]     ft_q, at_q;
	logic [EN_W-1:0] jm_q, jw_q, im_q, iw_q;
	logic [WIND_W-1:0] wind_q;
	logic [53:0]     diff_q;
	logic [32:0]     dt_q;
	logic [48:0]     dv_q;
	logic [63:0]     sq_q, pm_q, pw_q;
	logic [51:0]     loss_q;
	logic [PROD_W-1:0] acc_q;
	logic            sat_q;

	logic [EN_W-1:0] sum_m_q, sum_w_q;
	logic [JOINTS-1:0] vld_q;

	// Result register.
	logic               out_vld_q;
	logic [JOINT_W-1:0] out_joint_q;
	logic [EN_W-1:0]    out_m_q, out_w_q, out_tm_q, out_tw_q;
	logic               out_sat_q;

	logic acc_in, in_rng, out_free, st_we, coef_we;
	coef_t   coef_rd;
	jstate_t st_rd, st_wd;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;

	logic [PROD_W-1:0] vfull, ffull;
	logic [79:0]       pmf;
	logic [87:0]       lf, ef;
	logic [45:0]       dsh;
	logic [EN_W:0]     am, aw, sm, sw;

	jea_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .cfg_q(cfg_r));

	// Handshake.
	assign sample.ready = (state_q == S_IDLE);
	assign acc_in       = sample.valid && sample.ready;
	assign in_rng       = (32'(sample.joint) < JOINTS);
	assign out_free     = !out_vld_q || result.ready;
	assign coef_we      = acc_in && in_rng && (sample.req_type == REQ_LOAD);
	assign st_we        = (state_q == S_WB) && out_free;

	assign result.valid              = out_vld_q;
	assign result.out_joint          = out_joint_q;
	assign result.motor_energy       = out_m_q;
	assign result.walk_energy        = out_w_q;
	assign result.total_motor_energy = out_tm_q;
	assign result.total_walk_energy  = out_tw_q;
	assign result.saturated          = out_sat_q;

	// Coefficient and joint-state memories.
	jea_ram #(.WIDTH($bits(coef_t)), .DEPTH(JOINTS)) u_coef_ram (
		.clk(clk), .we(coef_we), .waddr(JIDX_W'(sample.joint)),
		.wdata({sample.gear_ratio, sample.winding_coef}),
		.raddr(JIDX_W'(sample.joint)), .rdata(coef_rd)
	);

	assign st_wd = '{last: scaled_q, fvel: fv_q, ftrq: ft_q, macc: jm_q, wacc: jw_q};

	jea_ram #(.WIDTH($bits(jstate_t)), .DEPTH(JOINTS)) u_state_ram (
		.clk(clk), .we(st_we), .waddr(jidx_q), .wdata(st_wd),
		.raddr(JIDX_W'(sample.joint)), .rdata(st_rd)
	);

	jea_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_q(prod_q));

	// Wide recombinations of split products.
	assign dsh   = diff_q[53:8];
	assign vfull = {prod_q[43:0], 23'b0} + acc_q;
	assign ffull = {prod_q[42:0], 24'b0} + acc_q;
	assign pmf   = {prod_q[55:0], 24'b0} + {24'b0, acc_q[55:0]};
	assign lf    = {prod_q[55:0], 32'b0} + {32'b0, acc_q[55:0]};
	assign ef    = {prod_q[55:0], 32'b0} + {32'b0, acc_q[55:0]};

	// Accumulator updates.
	assign am = add_sat48(jm_q, im_q);
	assign aw = add_sat48(jw_q, iw_q);
	assign sm = add_sat48(sum_m_q, im_q);
	assign sw = add_sat48(sum_w_q, iw_q);

	// Multiplier operand selection per step.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_LD: begin
				mul_a = {{2{pos_q[31]}}, pos_q};
				mul_b = {13'b0, coef_rd.gear};
			end
			S_V0: begin
				mul_a = {11'b0, dsh[22:0]};
				mul_b = {17'b0, cfg_r.rate};
			end
			S_V1: begin
				mul_a = {{11{dsh[45]}}, dsh[45:23]};
				mul_b = {17'b0, cfg_r.rate};
			end
			S_V2: begin
				mul_a = {dt_q[32], dt_q};
				mul_b = {17'b0, cfg_r.alpha};
			end
			S_F1: begin
				mul_a = {10'b0, dv_q[23:0]};
				mul_b = {17'b0, cfg_r.alpha};
			end
			S_F2: begin
				mul_a = {{9{dv_q[48]}}, dv_q[48:24]};
				mul_b = {17'b0, cfg_r.alpha};
			end
			S_P0: begin
				mul_a = {2'b0, at_q};
				mul_b = {1'b0, at_q};
			end
			S_P1: begin
				mul_a = {10'b0, av_q[23:0]};
				mul_b = {1'b0, at_q};
			end
			S_P2: begin
				mul_a = {10'b0, av_q[47:24]};
				mul_b = {1'b0, at_q};
			end
			S_P3: begin
				mul_a = {10'b0, wind_q};
				mul_b = {1'b0, sq_q[31:0]};
			end
			S_P4: begin
				mul_a = {10'b0, wind_q};
				mul_b = {1'b0, sq_q[63:32]};
			end
			S_P5: begin
				mul_a = {2'b0, pm_q[31:0]};
				mul_b = {9'b0, cfg_r.period};
			end
			S_P6: begin
				mul_a = {2'b0, pm_q[63:32]};
				mul_b = {9'b0, cfg_r.period};
			end
			S_P7: begin
				mul_a = {2'b0, pw_q[31:0]};
				mul_b = {9'b0, cfg_r.period};
			end
			S_P8: begin
				mul_a = {2'b0, pw_q[63:32]};
				mul_b = {9'b0, cfg_r.period};
			end
			default: ;
		endcase
	end

	// Datapath registers, one step per state.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			joint_q <= sample.joint;
			jidx_q  <= JIDX_W'(sample.joint);
			first_q <= sample.first_sample;
			pos_q   <= sample.position;
			tau_q   <= sample.torque;
		end
		case (state_q)
			S_LD: begin
				if (vld_q[jidx_q]) begin
					last_q <= st_rd.last;
					fv_q   <= st_rd.fvel;
					ft_q   <= st_rd.ftrq;
					jm_q   <= st_rd.macc;
					jw_q   <= st_rd.wacc;
				end else begin
					last_q <= '0;
					fv_q   <= '0;
					ft_q   <= '0;
					jm_q   <= '0;
					jw_q   <= '0;
				end
				wind_q <= coef_rd.wind;
			end
			S_SC: begin
				scaled_q <= prod_q[63:0];
				diff_q   <= prod_q[53:0] - last_q[53:0];
				dt_q     <= {tau_q[31], tau_q} - {ft_q[31], ft_q};
				if (first_q) begin
					fv_q  <= '0;
					ft_q  <= tau_q;
					jm_q  <= '0;
					jw_q  <= '0;
					sat_q <= 1'b0;
				end
			end
			S_V1: acc_q <= prod_q;
			S_V2: begin
				// Clamp the velocity to the signed 48-bit range.
				if (vfull[PROD_W-1] && (&vfull[PROD_W-1:47]) == 1'b0) begin
					vel_q <= {1'b1, 47'b0};
				end else if (!vfull[PROD_W-1] && (|vfull[PROD_W-1:47])) begin
					vel_q <= {1'b0, {47{1'b1}}};
				end else begin
					vel_q <= vfull[47:0];
				end
			end
			S_F0: begin
				ft_q <= ft_q + prod_q[47:16];
				dv_q <= {vel_q[47], vel_q} - {fv_q[47], fv_q};
			end
			S_F2: acc_q <= prod_q;
			S_F3: begin
				fv_q <= fv_q + ffull[63:16];
				at_q <= ft_q[31] ? (32'd0 - ft_q) : ft_q;
			end
			S_P0: av_q <= fv_q[47] ? (48'd0 - fv_q) : fv_q;
			S_P1: sq_q <= prod_q[63:0];
			S_P2: acc_q <= prod_q;
			S_P3: pm_q <= pmf[79:16];
			S_P4: acc_q <= prod_q;
			S_P5: loss_q <= lf[87:36];
			S_P6: begin
				acc_q <= prod_q;
				pw_q  <= pm_q + {12'b0, loss_q};
			end
			S_P7: im_q <= (|ef[87:72]) ? EN_FULL : ef[71:24];
			S_P8: acc_q <= prod_q;
			S_P9: iw_q <= (|ef[87:72]) ? EN_FULL : ef[71:24];
			S_AC: begin
				jm_q  <= am[EN_W-1:0];
				jw_q  <= aw[EN_W-1:0];
				sat_q <= am[EN_W] | aw[EN_W] | sm[EN_W] | sw[EN_W];
			end
			default: ;
		endcase
	end

	// Sequencer, totals, valid bits and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_m_q     <= '0;
			sum_w_q     <= '0;
			vld_q       <= '0;
			out_vld_q   <= 1'b0;
			out_joint_q <= '0;
			out_m_q     <= '0;
			out_w_q     <= '0;
			out_tm_q    <= '0;
			out_tw_q    <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			// Write-back reloads the result register itself when it is free.
			if (out_vld_q && result.ready && state_q != S_WB) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_in && in_rng && sample.req_type == REQ_SAMPLE) begin
						state_q <= S_LD;
					end
				end
				S_SC: begin
					if (first_q) begin
						if (joint_q == '0) begin
							sum_m_q <= '0;
							sum_w_q <= '0;
						end
						state_q <= S_WB;
					end else begin
						state_q <= S_V0;
					end
				end
				S_AC: begin
					sum_m_q <= sm[EN_W-1:0];
					sum_w_q <= sw[EN_W-1:0];
					state_q <= S_WB;
				end
				S_WB: begin
					if (out_free) begin
						vld_q[jidx_q] <= 1'b1;
						out_vld_q     <= 1'b1;
						out_joint_q   <= joint_q;
						out_m_q       <= jm_q;
						out_w_q       <= jw_q;
						out_tm_q      <= sum_m_q;
						out_tw_q      <= sum_w_q;
						out_sat_q     <= sat_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= state_t'(state_q + 5'd1);
			endcase
		end
	end

	`JEA_ASSERT_NXT(a_load_stays_idle, acc_in && sample.req_type == REQ_LOAD, state_q == S_IDLE, "load request left idle")
	`JEA_ASSERT_NXT(a_sample_starts, acc_in && in_rng && sample.req_type == REQ_SAMPLE, state_q == S_LD, "sample request did not start")
	`JEA_ASSERT_IMP(a_result_from_wb, $rose(out_vld_q), $past(state_q) == S_WB, "result raised outside write-back")
	`JEA_ASSERT_IMP(a_sat_full, out_vld_q && out_sat_q, out_m_q == EN_FULL || out_w_q == EN_FULL || out_tm_q == EN_FULL || out_tw_q == EN_FULL, "saturation flag without a full-scale energy")
endmodule

/* hdl/jea_ram.sv */
module jea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hdl/jea_mul.sv */
module jea_mul import jea_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_q
);
	// Shared signed multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule

/* hdl/jea_cfg.sv */
module jea_cfg import jea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	jea_cfg_if.sink     cfg,
	output cfg_t        cfg_q
);
	assign cfg.ready = 1'b1;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha  <= ALPHA_RST;
			cfg_q.rate   <= RATE_RST;
			cfg_q.period <= PERIOD_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_ALPHA:  cfg_q.alpha  <= cfg.data[15:0];
				CFG_RATE:   cfg_q.rate   <= cfg.data[15:0];
				CFG_PERIOD: cfg_q.period <= cfg.data[23:0];
				default: ;
			endcase
		end
	end
endmodule
